@@ src/qlp_pkg.sv @@
package qlp_pkg;

   // fixed field widths
   localparam int BLK_W      = 58;
   localparam int PC_W       = 16;
   localparam int OFF_W      = 6;
   localparam int ACT_W      = 3;
   localparam int Q_W        = 16;
   localparam int CRED_W     = 5;
   localparam int RNG_W      = 32;
   localparam int DIVISOR_W  = 16;
   localparam int REWARD_W   = 8;
   localparam int MULT_W     = 8;
   localparam int SHIFT_W    = 4;
   localparam int OFFSETS_W  = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // default build parameters
   localparam int DEF_PC_BITS      = 4;
   localparam int DEF_ACTION_COUNT = 8;
   localparam int DEF_EQ_DEPTH     = 16;
   localparam int DEF_Q_INITIAL    = 0;

   // random generator seed
   localparam logic [RNG_W-1:0] RNG_SEED = 32'h9E37_79B9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLORE_DIVISOR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USEFUL_REWARD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USELESS_REWARD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_MULTIPLIER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_SHIFT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT_SHIFT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTION_OFFSETS   = 3'd6;

   // register reset values
   localparam logic [DIVISOR_W-1:0] RST_EXPLORE_DIVISOR  = 16'd100;
   localparam logic [REWARD_W-1:0]  RST_USEFUL_REWARD    = 8'd20;
   localparam logic [REWARD_W-1:0]  RST_USELESS_REWARD   = 8'hF6;
   localparam logic [MULT_W-1:0]    RST_LEARN_MULTIPLIER = 8'd1;
   localparam logic [SHIFT_W-1:0]   RST_LEARN_SHIFT      = 4'd3;
   localparam logic [SHIFT_W-1:0]   RST_DISCOUNT_SHIFT   = 4'd1;

   // saturation bounds
   localparam logic signed [Q_W-1:0] Q_MAX = 16'sh7FFF;
   localparam logic signed [Q_W-1:0] Q_MIN = -16'sh8000;

   typedef enum logic [0:0] {
      QOP_LEARN,
      QOP_ARGMAX
   } qop_type;

   typedef struct packed {
      logic                       start;
      qop_type                    op;
      logic [ACT_W-1:0]           act;
      logic signed [REWARD_W-1:0] reward;
      logic [MULT_W-1:0]          mult;
      logic [SHIFT_W-1:0]         lshift;
      logic [SHIFT_W-1:0]         dshift;
   } qcmd_type;

   typedef struct packed {
      logic             ready;
      logic             done;
      logic [ACT_W-1:0] best_idx;
   } qstat_type;

   typedef enum logic [2:0] {
      QU_CLEAR,
      QU_IDLE,
      QU_BEST,
      QU_TD,
      QU_MUL,
      QU_WR,
      QU_ARG
   } qu_state_type;

   typedef enum logic [3:0] {
      T_IDLE,
      T_QRD,
      T_QCHK,
      T_LEARN,
      T_RNG,
      T_MODE,
      T_MODA,
      T_ARG,
      T_ISSUE,
      T_ERD,
      T_ECHK,
      T_PUSH,
      T_DONE
   } top_state_type;

endpackage

@@ src/qlp_rem.sv @@
module qlp_rem
   import qlp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RNG_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIVISOR_W-1:0] rem
);

   localparam int CNT_W = $clog2(RNG_W);

   logic                 running_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [RNG_W-1:0]     dv_ff;
   logic [DIVISOR_W-1:0] div_ff;
   logic [DIVISOR_W-1:0] r_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 ge;
   logic [DIVISOR_W:0]   diff;

   // one restoring step per cycle
   assign trial = {r_ff, dv_ff[RNG_W-1]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            running_ff <= 1'b1;
            cnt_ff     <= '0;
            dv_ff      <= dividend;
            div_ff     <= divisor;
            r_ff       <= '0;
         end else if (running_ff) begin
            dv_ff  <= {dv_ff[RNG_W-2:0], 1'b0};
            r_ff   <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RNG_W - 1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = r_ff;

endmodule

@@ src/qlp_qunit.sv @@
module qlp_qunit
   import qlp_pkg::*;
#(
   parameter int PC_BITS      = DEF_PC_BITS,
   parameter int ACTION_COUNT = DEF_ACTION_COUNT,
   parameter int Q_INITIAL    = DEF_Q_INITIAL
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  qcmd_type                   cmd,
   input  logic [PC_BITS+OFF_W-1:0]   sid,
   input  logic [PC_BITS+OFF_W-1:0]   cur,
   output qstat_type                  stat
);

   localparam int SID_W    = PC_BITS + OFF_W;
   localparam int N_STATES = 1 << SID_W;
   localparam int ROW_W    = ACTION_COUNT * Q_W;
   localparam int TD_W     = Q_W + 2;
   localparam int PROD_W   = TD_W + MULT_W + 1;
   localparam int NQ_W     = PROD_W + 1;
   localparam logic [ROW_W-1:0] INIT_ROW = {ACTION_COUNT{Q_W'(Q_INITIAL)}};

   // one row of q values per state
   logic [ROW_W-1:0] q_mem [N_STATES];

   qu_state_type             state_ff, state_in;
   logic [SID_W-1:0]         clr_ff;
   logic [SID_W-1:0]         sid_ff;
   logic [ACT_W-1:0]         act_ff;
   logic signed [REWARD_W-1:0] reward_ff;
   qop_type                  op_ff;
   logic [ROW_W-1:0]         rd_ff;
   logic [ROW_W-1:0]         row_ff;
   logic signed [Q_W-1:0]    best_ff;
   logic signed [TD_W-1:0]   td_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                     ren;
   logic [SID_W-1:0]         raddr;
   logic                     we;
   logic [SID_W-1:0]         waddr;
   logic [ROW_W-1:0]         wdata;
   logic                     done;

   logic signed [Q_W-1:0]    best;
   logic [ACT_W-1:0]         best_idx;
   logic signed [Q_W-1:0]    q_rd;
   logic signed [Q_W-1:0]    q_row;
   logic signed [Q_W-1:0]    best_sh;
   logic signed [TD_W-1:0]   td;
   logic signed [PROD_W-1:0] step;
   logic signed [NQ_W-1:0]   nq;
   logic signed [Q_W-1:0]    nq_sat;

   // memory ports
   always_ff @(posedge clock) begin
      if (we) begin
         q_mem[waddr] <= wdata;
      end
      if (ren) begin
         rd_ff <= q_mem[raddr];
      end
   end

   // argmax over the row just read, lowest index wins ties
   always_comb begin
      best     = $signed(rd_ff[Q_W-1:0]);
      best_idx = '0;
      for (int a = 1; a < ACTION_COUNT; a++) begin
         if ($signed(rd_ff[a*Q_W +: Q_W]) > best) begin
            best     = $signed(rd_ff[a*Q_W +: Q_W]);
            best_idx = ACT_W'(a);
         end
      end
   end

   // temporal difference and update arithmetic
   assign q_rd    = $signed(rd_ff[act_ff*Q_W +: Q_W]);
   assign q_row   = $signed(row_ff[act_ff*Q_W +: Q_W]);
   assign best_sh = best_ff >>> cmd.dshift;
   assign td      = TD_W'(reward_ff) + TD_W'(best_sh) - TD_W'(q_rd);
   assign step    = prod_ff >>> cmd.lshift;
   assign nq      = NQ_W'(q_row) + NQ_W'(step);

   always_comb begin
      if (nq > NQ_W'(Q_MAX)) begin
         nq_sat = Q_MAX;
      end else if (nq < NQ_W'(Q_MIN)) begin
         nq_sat = Q_MIN;
      end else begin
         nq_sat = nq[Q_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ren      = 1'b0;
      raddr    = cur;
      we       = 1'b0;
      waddr    = clr_ff;
      wdata    = INIT_ROW;
      done     = 1'b0;
      unique case (state_ff)
         QU_CLEAR: begin
            we = 1'b1;
            if (clr_ff == SID_W'(N_STATES - 1)) begin
               state_in = QU_IDLE;
            end
         end
         QU_IDLE: begin
            if (cmd.start) begin
               ren      = 1'b1;
               raddr    = cur;
               state_in = (cmd.op == QOP_ARGMAX) ? QU_ARG : QU_BEST;
            end
         end
         QU_BEST: begin
            ren      = 1'b1;
            raddr    = sid_ff;
            state_in = QU_TD;
         end
         QU_TD: begin
            state_in = QU_MUL;
         end
         QU_MUL: begin
            state_in = QU_WR;
         end
         QU_WR: begin
            we       = 1'b1;
            waddr    = sid_ff;
            wdata    = row_ff;
            wdata[act_ff*Q_W +: Q_W] = nq_sat;
            done     = 1'b1;
            state_in = QU_IDLE;
         end
         QU_ARG: begin
            done     = 1'b1;
            state_in = QU_IDLE;
         end
         default: begin
            state_in = QU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= QU_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == QU_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == QU_IDLE && cmd.start) begin
         sid_ff    <= sid;
         act_ff    <= cmd.act;
         reward_ff <= cmd.reward;
         op_ff     <= cmd.op;
      end
      if (state_ff == QU_BEST) begin
         best_ff <= best;
      end
      if (state_ff == QU_TD) begin
         td_ff  <= td;
         row_ff <= rd_ff;
      end
      if (state_ff == QU_MUL && op_ff == QOP_LEARN) begin
         prod_ff <= td_ff * $signed({1'b0, cmd.mult});
      end
   end

   assign stat.ready    = (state_ff != QU_CLEAR);
   assign stat.done     = done;
   assign stat.best_idx = best_idx;

endmodule

@@ src/q_learning_prefetcher.sv @@
// Q-learning prefetcher: one result beat per demand beat. After reset the Q store is
// swept to its initial value one state row per cycle (2^(PC_BITS+6) rows, 1024 by
// default) while req_stall stays high; register writes are taken throughout. An item
// then scans each queue entry, runs a Q update for each useful credit, runs the
// explore test unless the explore divisor is zero, pushes an accepted prefetch, evicts
// the head when the queue is full (with a Q update when the evicted entry was unused),
// and waits for a free output register while rsp_stall holds the last result beat.
// Item processing is paced by the bit-serial remainder unit, the queue scan that reads
// one entry at a time and the read-modify-write of Q rows through the state memory.
module q_learning_prefetcher
   import qlp_pkg::*;
#(
   parameter int PC_BITS      = DEF_PC_BITS,
   parameter int ACTION_COUNT = DEF_ACTION_COUNT,
   parameter int EQ_DEPTH     = DEF_EQ_DEPTH,
   parameter int Q_INITIAL    = DEF_Q_INITIAL
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BLK_W-1:0]      req_block_address,
   input  logic [PC_W-1:0]       req_pc_low,
   input  logic                  req_prefetch_accepted,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_prefetch_valid,
   output logic [BLK_W-1:0]      rsp_prefetch_block,
   output logic [ACT_W-1:0]      rsp_action_index,
   output logic [CRED_W-1:0]     rsp_useful_credits,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int SID_W = PC_BITS + OFF_W;
   localparam int QI_W  = $clog2(EQ_DEPTH);
   localparam int CNT_W = $clog2(EQ_DEPTH + 1);
   localparam int EW    = BLK_W + SID_W + ACT_W + 1;

   // reciprocal constants for the action draw modulo the action count
   localparam int     RCP_SH  = 16 + $clog2(ACTION_COUNT);
   localparam longint RCP_M   = ((longint'(1) << RCP_SH) + longint'(ACTION_COUNT) - 1)
                                / longint'(ACTION_COUNT);
   localparam int     HALF_WT = (1 << 16) % ACTION_COUNT;

   // evaluation queue: {used, action, state, block}
   logic [EW-1:0] eq_mem [EQ_DEPTH];

   // configuration
   logic [DIVISOR_W-1:0]       ediv_ff;
   logic signed [REWARD_W-1:0] useful_ff;
   logic signed [REWARD_W-1:0] useless_ff;
   logic [MULT_W-1:0]          mult_ff;
   logic [SHIFT_W-1:0]         lshift_ff;
   logic [SHIFT_W-1:0]         dshift_ff;
   logic [OFFSETS_W-1:0]       offsets_ff;

   // control state
   top_state_type    state_ff, state_in;
   logic [QI_W-1:0]  head_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] k_ff;
   logic [RNG_W-1:0] rng_ff;
   logic [RNG_W-1:0] x_ff;
   logic [5:0]       xmod_ff;
   logic             evict_ff;
   logic             ret_push_ff;
   logic             rsp_valid_ff;

   // item registers
   logic [BLK_W-1:0]   blk_ff;
   logic [PC_BITS-1:0] pc_ff;
   logic               acc_ff;
   logic [CRED_W-1:0]  credits_ff;
   logic [ACT_W-1:0]   act_ff;
   logic               pv_ff;
   logic [BLK_W-1:0]   pblk_ff;
   logic [EW-1:0]      e_rd_ff;
   logic               o_pv_ff;
   logic [BLK_W-1:0]   o_pblk_ff;
   logic [ACT_W-1:0]   o_act_ff;
   logic [CRED_W-1:0]  o_cred_ff;

   // combinational
   logic [SID_W-1:0]     s_cur;
   logic [QI_W-1:0]      scan_addr;
   logic [BLK_W-1:0]     e_blk;
   logic [SID_W-1:0]     e_sid;
   logic [ACT_W-1:0]     e_act;
   logic                 e_used;
   logic                 e_match;
   logic                 e_ren;
   logic [QI_W-1:0]      e_raddr;
   logic                 e_we;
   logic [QI_W-1:0]      e_waddr;
   logic [EW-1:0]        e_wdata;
   logic [QI_W-1:0]      head_n;
   logic [CNT_W-1:0]     cnt_eff;
   logic [RNG_W-1:0]     xs_a, xs_b, xs;
   logic signed [7:0]    off;
   logic signed [8:0]    tgt;
   logic                 hit;
   logic [BLK_W-1:0]     pblk;
   logic                 out_free;
   qcmd_type             qcmd;
   logic [SID_W-1:0]     qsid;
   qstat_type            qstat;
   logic                 rem_start;
   logic [DIVISOR_W-1:0] rem_divisor;
   logic                 rem_done;
   logic [DIVISOR_W-1:0] rem_val;

   function automatic logic [QI_W-1:0] wrap_add(input logic [QI_W-1:0] a,
                                                input logic [QI_W-1:0] b);
      logic [QI_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (QI_W+1)'(EQ_DEPTH)) begin
         s = s - (QI_W+1)'(EQ_DEPTH);
      end
      return s[QI_W-1:0];
   endfunction

   // 16-bit value modulo the action count by reciprocal multiplication
   function automatic logic [ACT_W-1:0] mod_act(input logic [15:0] v);
      logic [35:0] prod;
      logic [15:0] quo;
      logic [15:0] r;
      prod = 36'(v) * 36'(RCP_M);
      quo  = prod[RCP_SH +: 16];
      r    = v - 16'(quo * 16'(ACTION_COUNT));
      return r[ACT_W-1:0];
   endfunction

   qlp_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (xs),
      .divisor  (rem_divisor),
      .done     (rem_done),
      .rem      (rem_val)
   );

   qlp_qunit #(
      .PC_BITS      (PC_BITS),
      .ACTION_COUNT (ACTION_COUNT),
      .Q_INITIAL    (Q_INITIAL)
   ) u_qunit (
      .clock (clock),
      .reset (reset),
      .cmd   (qcmd),
      .sid   (qsid),
      .cur   (s_cur),
      .stat  (qstat)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ediv_ff    <= RST_EXPLORE_DIVISOR;
         useful_ff  <= RST_USEFUL_REWARD;
         useless_ff <= RST_USELESS_REWARD;
         mult_ff    <= RST_LEARN_MULTIPLIER;
         lshift_ff  <= RST_LEARN_SHIFT;
         dshift_ff  <= RST_DISCOUNT_SHIFT;
         offsets_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXPLORE_DIVISOR:  ediv_ff    <= csr_write_data[DIVISOR_W-1:0];
            CSR_USEFUL_REWARD:    useful_ff  <= csr_write_data[REWARD_W-1:0];
            CSR_USELESS_REWARD:   useless_ff <= csr_write_data[REWARD_W-1:0];
            CSR_LEARN_MULTIPLIER: mult_ff    <= csr_write_data[MULT_W-1:0];
            CSR_LEARN_SHIFT:      lshift_ff  <= csr_write_data[SHIFT_W-1:0];
            CSR_DISCOUNT_SHIFT:   dshift_ff  <= csr_write_data[SHIFT_W-1:0];
            CSR_ACTION_OFFSETS:   offsets_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // queue memory ports
   always_ff @(posedge clock) begin
      if (e_we) begin
         eq_mem[e_waddr] <= e_wdata;
      end
      if (e_ren) begin
         e_rd_ff <= eq_mem[e_raddr];
      end
   end

   // field decode and address helpers
   assign s_cur     = {pc_ff, blk_ff[OFF_W-1:0]};
   assign scan_addr = wrap_add(head_ff, k_ff[QI_W-1:0]);
   assign e_blk     = e_rd_ff[BLK_W-1:0];
   assign e_sid     = e_rd_ff[BLK_W +: SID_W];
   assign e_act     = e_rd_ff[BLK_W+SID_W +: ACT_W];
   assign e_used    = e_rd_ff[EW-1];
   assign e_match   = !e_used && (e_blk == blk_ff);
   assign head_n    = evict_ff ? wrap_add(head_ff, QI_W'(1)) : head_ff;
   assign cnt_eff   = evict_ff ? count_ff - 1'b1 : count_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // xorshift32 step
   assign xs_a = rng_ff ^ (rng_ff << 13);
   assign xs_b = xs_a ^ (xs_a >> 17);
   assign xs   = xs_b ^ (xs_b << 5);

   // prefetch target within the page
   assign off  = $signed(offsets_ff[act_ff*8 +: 8]);
   assign tgt  = $signed({3'b000, blk_ff[OFF_W-1:0]}) + 9'(off);
   assign hit  = (off != 8'sd0) && (tgt[8:6] == 3'b000);
   assign pblk = {blk_ff[BLK_W-1:OFF_W], tgt[OFF_W-1:0]};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      e_ren       = 1'b0;
      e_raddr     = scan_addr;
      e_we        = 1'b0;
      e_waddr     = scan_addr;
      e_wdata     = {1'b1, e_rd_ff[EW-2:0]};
      qcmd.start  = 1'b0;
      qcmd.op     = QOP_LEARN;
      qcmd.act    = e_act;
      qcmd.reward = useful_ff;
      qcmd.mult   = mult_ff;
      qcmd.lshift = lshift_ff;
      qcmd.dshift = dshift_ff;
      qsid        = e_sid;
      rem_start   = 1'b0;
      rem_divisor = ediv_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in = T_QRD;
            end
         end
         T_QRD: begin
            if (k_ff == count_ff) begin
               state_in = T_RNG;
            end else begin
               e_ren    = 1'b1;
               state_in = T_QCHK;
            end
         end
         T_QCHK: begin
            if (e_match) begin
               e_we       = 1'b1;
               qcmd.start = 1'b1;
               state_in   = T_LEARN;
            end else begin
               state_in = T_QRD;
            end
         end
         T_LEARN: begin
            if (qstat.done) begin
               state_in = ret_push_ff ? T_PUSH : T_QRD;
            end
         end
         T_RNG: begin
            if (ediv_ff != '0) begin
               state_in = T_MODE;
            end else begin
               qcmd.start = 1'b1;
               qcmd.op    = QOP_ARGMAX;
               state_in   = T_ARG;
            end
         end
         T_MODE: begin
            if (rem_done) begin
               if (rem_val == '0) begin
                  state_in = T_MODA;
               end else begin
                  qcmd.start = 1'b1;
                  qcmd.op    = QOP_ARGMAX;
                  state_in   = T_ARG;
               end
            end
         end
         T_MODA: begin
            state_in = T_ISSUE;
         end
         T_ARG: begin
            if (qstat.done) begin
               state_in = T_ISSUE;
            end
         end
         T_ISSUE: begin
            if (hit && acc_ff) begin
               state_in = (count_ff == CNT_W'(EQ_DEPTH)) ? T_ERD : T_PUSH;
            end else begin
               state_in = T_DONE;
            end
         end
         T_ERD: begin
            e_ren    = 1'b1;
            e_raddr  = head_ff;
            state_in = T_ECHK;
         end
         T_ECHK: begin
            if (!e_used) begin
               qcmd.start  = 1'b1;
               qcmd.reward = useless_ff;
               state_in    = T_LEARN;
            end else begin
               state_in = T_PUSH;
            end
         end
         T_PUSH: begin
            e_we     = 1'b1;
            e_waddr  = wrap_add(head_n, cnt_eff[QI_W-1:0]);
            e_wdata  = {1'b0, act_ff, s_cur, pblk_ff};
            state_in = T_DONE;
         end
         T_DONE: begin
            if (out_free) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
      // explore test starts right after the draw
      if (state_ff == T_RNG && ediv_ff != '0) begin
         rem_start = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rng_ff       <= RNG_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == T_RNG) begin
            rng_ff <= xs;
         end
         if (state_ff == T_PUSH) begin
            head_ff  <= head_n;
            count_ff <= cnt_eff + 1'b1;
         end
         if (state_ff == T_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == T_IDLE && req_valid && !req_stall) begin
         blk_ff      <= req_block_address;
         pc_ff       <= req_pc_low[PC_BITS-1:0];
         acc_ff      <= req_prefetch_accepted;
         k_ff        <= '0;
         credits_ff  <= '0;
         evict_ff    <= 1'b0;
         ret_push_ff <= 1'b0;
      end
      if (state_ff == T_QCHK) begin
         k_ff <= k_ff + 1'b1;
         if (e_match) begin
            credits_ff <= credits_ff + 1'b1;
         end
      end
      if (state_ff == T_RNG) begin
         x_ff <= xs;
      end
      // fold the draw halves while the explore test runs
      if (state_ff == T_MODE) begin
         xmod_ff <= 6'(HALF_WT) * 6'(mod_act(x_ff[31:16])) + 6'(mod_act(x_ff[15:0]));
      end
      if (state_ff == T_MODA) begin
         act_ff <= mod_act({10'b0, xmod_ff});
      end
      if (state_ff == T_ARG && qstat.done) begin
         act_ff <= qstat.best_idx;
      end
      if (state_ff == T_ISSUE) begin
         pv_ff   <= hit;
         pblk_ff <= hit ? pblk : '0;
      end
      if (state_ff == T_ECHK) begin
         evict_ff    <= 1'b1;
         ret_push_ff <= 1'b1;
      end
      if (state_ff == T_DONE && out_free) begin
         o_pv_ff   <= pv_ff;
         o_pblk_ff <= pblk_ff;
         o_act_ff  <= act_ff;
         o_cred_ff <= credits_ff;
      end
   end

   assign req_stall          = !(state_ff == T_IDLE && qstat.ready);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_prefetch_valid = o_pv_ff;
   assign rsp_prefetch_block = o_pblk_ff;
   assign rsp_action_index   = o_act_ff;
   assign rsp_useful_credits = o_cred_ff;

   // queue occupancy stays within its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(EQ_DEPTH))
      else $error("queue count beyond depth");

   // an accepted beat starts the queue scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == T_QRD))
      else $error("accepted beat did not start scan");

   // a push without eviction grows the queue by one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_PUSH && !evict_ff) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("push did not grow queue");

   // a finished item with a free output register shows up next cycle
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result beat not presented");

endmodule
